@@ rtl/mcg_pkg.sv @@
// Package for the month calendar generator.
// Holds the command and status structs, the controller state encoding and the
// month tables. Depends on nothing.
`default_nettype none

package mcg_pkg;

   localparam int MonthWidth = 4;
   localparam int YearWidth  = 14;
   localparam int DayWidth   = 5;
   localparam int WdayWidth  = 3;

   // Zeller year: the year moved forward by one Gregorian cycle, less one for January and February.
   localparam int ZyWidth    = 15;
   localparam int CycleYears = 400;
   localparam int Century    = 100;

   // Reciprocal of 100 and its shift, exact for every value below 2**15.
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;
   localparam int QuotWidth     = 8;
   localparam int RemWidth      = 7;

   // The congruence sum stays below 1100, and its reciprocal of 7.
   localparam int SumWidth     = 11;
   localparam int Recip7       = 9363;
   localparam int Recip7Shift  = 16;
   localparam int Week         = 7;
   localparam int LastWeekday  = 6;

   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthApr = 4'd4;
   localparam logic [MonthWidth-1:0] MonthJun = 4'd6;
   localparam logic [MonthWidth-1:0] MonthSep = 4'd9;
   localparam logic [MonthWidth-1:0] MonthNov = 4'd11;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_SUM   = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_FIRST = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic divide;
      logic sum;
      logic modulo;
      logic first;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic last;
   } status_type;

   // Month term of the congruence, floor(13 * (zm + 1) / 5), where January and
   // February count as months 13 and 14.
   function automatic logic [5:0] month_term(input logic [MonthWidth-1:0] m);
      logic [5:0] t;
      unique case (m)
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   function automatic logic [DayWidth-1:0] month_days(input logic [MonthWidth-1:0] m,
                                                      input logic leap);
      logic [DayWidth-1:0] d;
      priority if (m == MonthFeb) begin
         d = leap ? 5'd29 : 5'd28;
      end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
         d = 5'd30;
      end else begin
         d = 5'd31;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/month_calendar_generator_top.sv @@
// Top level of the month calendar generator.
// Instantiates mcg_ctrl and mcg_datapath; depends on mcg_pkg.
//
// Usage:
// A request carries a month (1 = January .. 12 = December) and a Gregorian
// year. It is transferred on a rising edge with req_valid high and req_stall
// low. The block then produces one result transfer per day of the month, in
// order, each with the day number, its weekday (0 = Saturday .. 6 = Friday)
// and the month length; rsp_last_day marks the final day. A month outside
// 1..12 produces a single result with rsp_bad_month and rsp_last_day set and
// all other fields zero.
//
// Sequence: the steps from the request transfer are: load, divide by 100
// through a reciprocal multiply, form the congruence sum, reduce it modulo 7
// through a second reciprocal multiply, and set up the first day. A bad
// month goes from the divide step straight to its result. Days then follow
// one per cycle while the receiver does not raise rsp_stall; req_stall stays
// high from the request transfer until the last result has been transferred.
// When the receiver raises rsp_stall, the current result holds unchanged.
// Reset returns the controller to idle and drops any run in progress.
`default_nettype none

module month_calendar_generator_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [mcg_pkg::MonthWidth-1:0]     req_month,
   input  wire  [mcg_pkg::YearWidth-1:0]      req_year,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [mcg_pkg::DayWidth-1:0]       rsp_day_of_month,
   output logic [mcg_pkg::WdayWidth-1:0]      rsp_weekday,
   output logic [mcg_pkg::DayWidth-1:0]       rsp_month_length,
   output logic                               rsp_last_day,
   output logic                               rsp_bad_month
);

   mcg_pkg::cmd_type    cmd;
   mcg_pkg::status_type status;

   // The controller owns both handshakes; the datapath only sees commands.
   mcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath registers drive the result fields directly, so a stalled
   // result holds until the controller issues the next advance.
   mcg_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .req_month (req_month),
      .req_year  (req_year),
      .day       (rsp_day_of_month),
      .weekday   (rsp_weekday),
      .length    (rsp_month_length),
      .bad       (rsp_bad_month)
   );

   // The last day is reached when the day counter meets the month length; an
   // error result has both at zero.
   assign rsp_last_day = status.last;

endmodule

`default_nettype wire

@@ rtl/mcg_datapath.sv @@
// Datapath of the month calendar generator: request registers, the congruence
// arithmetic and the day counter that feeds the result ports.
// Depends on mcg_pkg.
`default_nettype none

module mcg_datapath (
   input  wire                                 clock,
   input  mcg_pkg::cmd_type                    cmd,
   output mcg_pkg::status_type                 status,
   input  wire  [mcg_pkg::MonthWidth-1:0]      req_month,
   input  wire  [mcg_pkg::YearWidth-1:0]       req_year,
   output logic [mcg_pkg::DayWidth-1:0]        day,
   output logic [mcg_pkg::WdayWidth-1:0]       weekday,
   output logic [mcg_pkg::DayWidth-1:0]        length,
   output logic                                bad
);

   localparam int ProdWidth = mcg_pkg::ZyWidth + 13;
   localparam int Prod7     = mcg_pkg::SumWidth + 14;

   logic [mcg_pkg::MonthWidth-1:0] month_ff;
   logic [mcg_pkg::YearWidth-1:0]  year_ff;
   logic [mcg_pkg::ZyWidth-1:0]    zy_ff, zy_in;
   logic [mcg_pkg::QuotWidth-1:0]  j_ff, yh_ff;
   logic [mcg_pkg::SumWidth-1:0]   sum_ff, sum_in;
   logic [mcg_pkg::QuotWidth-1:0]  q_ff;
   logic [mcg_pkg::DayWidth-1:0]   day_ff, len_ff;
   logic [mcg_pkg::WdayWidth-1:0]  wd_ff;
   logic                           bad_ff, bad_in;

   logic [ProdWidth-1:0]          zy_prod, y_prod;
   logic [Prod7-1:0]              s_prod;
   logic [mcg_pkg::ZyWidth-1:0]   k_full, yr_full;
   logic [mcg_pkg::RemWidth-1:0]  k, yr;
   logic                          leap;
   logic [mcg_pkg::SumWidth-1:0]  wd_full;

   assign bad_in = (req_month == '0) || (req_month > mcg_pkg::MonthDec);
   assign zy_in  = {1'b0, req_year} + mcg_pkg::ZyWidth'(mcg_pkg::CycleYears)
                   - mcg_pkg::ZyWidth'(req_month <= mcg_pkg::MonthFeb);

   assign zy_prod = ProdWidth'(zy_ff) * ProdWidth'(mcg_pkg::Recip100);
   assign y_prod  = ProdWidth'(year_ff) * ProdWidth'(mcg_pkg::Recip100);

   // Remainders by 100 from the registered quotients.
   assign k_full  = zy_ff - mcg_pkg::ZyWidth'(j_ff) * mcg_pkg::ZyWidth'(mcg_pkg::Century);
   assign yr_full = {1'b0, year_ff}
                    - mcg_pkg::ZyWidth'(yh_ff) * mcg_pkg::ZyWidth'(mcg_pkg::Century);
   assign k  = k_full[mcg_pkg::RemWidth-1:0];
   assign yr = yr_full[mcg_pkg::RemWidth-1:0];

   // Divisible by 4 but not by 100, or divisible by 400.
   assign leap = ((year_ff[1:0] == 2'b00) && (yr != '0))
                 || ((yr == '0) && (yh_ff[1:0] == 2'b00));

   assign sum_in = mcg_pkg::SumWidth'(1)
                   + mcg_pkg::SumWidth'(mcg_pkg::month_term(month_ff))
                   + mcg_pkg::SumWidth'(k) + mcg_pkg::SumWidth'(k >> 2)
                   + mcg_pkg::SumWidth'(j_ff >> 2)
                   + mcg_pkg::SumWidth'(j_ff) * mcg_pkg::SumWidth'(5);

   assign s_prod  = Prod7'(sum_ff) * Prod7'(mcg_pkg::Recip7);
   assign wd_full = sum_ff - mcg_pkg::SumWidth'(q_ff) * mcg_pkg::SumWidth'(mcg_pkg::Week);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         month_ff <= req_month;
         year_ff  <= req_year;
         zy_ff    <= zy_in;
         bad_ff   <= bad_in;
         // An error result carries zeros and is its own last result.
         day_ff   <= '0;
         wd_ff    <= '0;
         len_ff   <= '0;
      end
      if (cmd.divide) begin
         j_ff  <= zy_prod[mcg_pkg::Recip100Shift +: mcg_pkg::QuotWidth];
         yh_ff <= y_prod[mcg_pkg::Recip100Shift +: mcg_pkg::QuotWidth];
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
         len_ff <= mcg_pkg::month_days(month_ff, leap);
      end
      if (cmd.modulo) begin
         q_ff <= s_prod[mcg_pkg::Recip7Shift +: mcg_pkg::QuotWidth];
      end
      if (cmd.first) begin
         day_ff <= mcg_pkg::DayWidth'(1);
         wd_ff  <= wd_full[mcg_pkg::WdayWidth-1:0];
      end
      if (cmd.advance) begin
         day_ff <= day_ff + mcg_pkg::DayWidth'(1);
         wd_ff  <= (wd_ff == mcg_pkg::WdayWidth'(mcg_pkg::LastWeekday))
                   ? '0 : wd_ff + mcg_pkg::WdayWidth'(1);
      end
   end

   assign status.bad  = bad_ff;
   assign status.last = (day_ff == len_ff);

   assign day     = day_ff;
   assign weekday = wd_ff;
   assign length  = len_ff;
   assign bad     = bad_ff;

endmodule

`default_nettype wire

@@ rtl/mcg_ctrl.sv @@
// Controller of the month calendar generator: sequences the arithmetic steps
// and the per-day result transfers. Depends on mcg_pkg.
`default_nettype none

module mcg_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  mcg_pkg::status_type   status,
   output mcg_pkg::cmd_type      cmd
);

   mcg_pkg::state_type state_ff, state_in;

   logic take;
   logic give;

   // No request is taken while reset is held, so none can be dropped by it.
   assign req_stall = reset || (state_ff != mcg_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == mcg_pkg::ST_EMIT);
   assign take      = req_valid && !req_stall;
   assign give      = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcg_pkg::ST_IDLE:  if (take) state_in = mcg_pkg::ST_DIV;
         mcg_pkg::ST_DIV:   state_in = status.bad ? mcg_pkg::ST_EMIT : mcg_pkg::ST_SUM;
         mcg_pkg::ST_SUM:   state_in = mcg_pkg::ST_MOD;
         mcg_pkg::ST_MOD:   state_in = mcg_pkg::ST_FIRST;
         mcg_pkg::ST_FIRST: state_in = mcg_pkg::ST_EMIT;
         mcg_pkg::ST_EMIT:  if (give && status.last) state_in = mcg_pkg::ST_IDLE;
         default:           state_in = mcg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.load    = take;
      cmd.divide  = (state_ff == mcg_pkg::ST_DIV);
      cmd.sum     = (state_ff == mcg_pkg::ST_SUM);
      cmd.modulo  = (state_ff == mcg_pkg::ST_MOD);
      cmd.first   = (state_ff == mcg_pkg::ST_FIRST);
      cmd.advance = give && !status.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
